FILE: sv/shs_pkg.sv
// Shared types, codes and the half-step coil table for the stepper sequencer.
// No dependencies; used by shs_core and stepper_half_step_sequencer.
`default_nettype none

package shs_pkg;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_BITS = $clog2(PHASE_COUNT);
	localparam int COIL_BITS = 4;
	localparam int STATUS_BITS = 3;
	localparam int CMD_BITS = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int COUNT_BITS_DEF = 16;
	localparam int DELAY_BITS_DEF = 24;
	localparam int STEP_DELAY_RST = 7500;

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_FWD = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_BWD = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_DELAY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FWD_PRESENT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BWD_PRESENT = 2'd2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_IDLE = 3'd0,
		ST_STEP = 3'd1,
		ST_ACCEPT = 3'd2,
		ST_LIMIT = 3'd3,
		ST_BUSY = 3'd4
	} status_t;

	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic fwd_level;
		logic bwd_level;
	} item_ctl_t;

	typedef struct packed {
		logic fwd_present;
		logic bwd_present;
	} sw_cfg_t;

	// active-low half-step pattern, bit0 drives coil line one
	function automatic logic [COIL_BITS-1:0] coil_of(input logic [PHASE_BITS-1:0] ph);
		logic [COIL_BITS-1:0] c;
		case (ph)
			3'd0: c = 4'hE;
			3'd1: c = 4'hC;
			3'd2: c = 4'hD;
			3'd3: c = 4'h9;
			3'd4: c = 4'hB;
			3'd5: c = 4'h3;
			3'd6: c = 4'h7;
			3'd7: c = 4'h6;
			default: c = 4'hE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/stepper_half_step_sequencer.sv
// Path: a request accepted into the input register moves on to the result
// register. Throughput: one request per cycle, set by the state update in
// shs_core; stalls only when out_ready is low.
// Reset: phase 0, coil 0xE, no move pending, tick counter saturated,
// step_delay 7500, both limit switches not fitted, no result pending.
// Depends on shs_pkg and shs_core.
`default_nettype none

module stepper_half_step_sequencer #(
	parameter int COUNT_BITS = shs_pkg::COUNT_BITS_DEF,
	parameter int DELAY_BITS = shs_pkg::DELAY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [shs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [DELAY_BITS-1:0] cfg_data,

	input wire logic in_valid,
	output logic in_ready,
	input wire logic [shs_pkg::CMD_BITS-1:0] cmd,
	input wire logic [COUNT_BITS-1:0] step_count,
	input wire logic forward_switch_level,
	input wire logic backward_switch_level,

	output logic out_valid,
	input wire logic out_ready,
	output logic [shs_pkg::COIL_BITS-1:0] coil_pattern,
	output logic [shs_pkg::STATUS_BITS-1:0] status,
	output logic busy_res,
	output logic [COUNT_BITS-1:0] steps_left
);

	logic [DELAY_BITS-1:0] step_delay_q;
	shs_pkg::sw_cfg_t sw_q;

	logic v_s1;
	shs_pkg::item_ctl_t ctl_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic adv;

	shs_pkg::status_t status_nxt;
	logic [shs_pkg::COIL_BITS-1:0] coil_nxt;
	logic [COUNT_BITS-1:0] remaining_nxt;

	logic out_valid_q;
	logic [shs_pkg::COIL_BITS-1:0] coil_q;
	shs_pkg::status_t status_q;
	logic busy_q;
	logic [COUNT_BITS-1:0] steps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q <= DELAY_BITS'(shs_pkg::STEP_DELAY_RST);
			sw_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				shs_pkg::REG_STEP_DELAY: step_delay_q <= cfg_data;
				shs_pkg::REG_FWD_PRESENT: sw_q.fwd_present <= cfg_data[0];
				shs_pkg::REG_BWD_PRESENT: sw_q.bwd_present <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request moves on when the result register is free or being drained
	assign adv = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s1.cmd <= cmd;
			ctl_s1.fwd_level <= forward_switch_level;
			ctl_s1.bwd_level <= backward_switch_level;
			count_s1 <= step_count;
		end
	end

	shs_core #(
		.COUNT_BITS(COUNT_BITS),
		.DELAY_BITS(DELAY_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctl(ctl_s1),
		.count(count_s1),
		.step_delay(step_delay_q),
		.sw(sw_q),
		.status_nxt(status_nxt),
		.coil_nxt(coil_nxt),
		.remaining_nxt(remaining_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coil_q <= coil_nxt;
			status_q <= status_nxt;
			busy_q <= (remaining_nxt != '0);
			steps_q <= remaining_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign coil_pattern = coil_q;
	assign status = status_q;
	assign busy_res = busy_q;
	assign steps_left = steps_q;

endmodule

`default_nettype wire

FILE: sv/shs_core.sv
// Sequencer state (phase, step count, direction, tick counter, coil latch)
// and the per-request update logic. Depends on shs_pkg.
`default_nettype none

module shs_core #(
	parameter int COUNT_BITS = shs_pkg::COUNT_BITS_DEF,
	parameter int DELAY_BITS = shs_pkg::DELAY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire shs_pkg::item_ctl_t ctl,
	input wire logic [COUNT_BITS-1:0] count,
	input wire logic [DELAY_BITS-1:0] step_delay,
	input wire shs_pkg::sw_cfg_t sw,
	output shs_pkg::status_t status_nxt,
	output logic [shs_pkg::COIL_BITS-1:0] coil_nxt,
	output logic [COUNT_BITS-1:0] remaining_nxt
);

	logic [shs_pkg::PHASE_BITS-1:0] phase_q, phase_nxt;
	logic [COUNT_BITS-1:0] remaining_q;
	logic backward_q, backward_nxt;
	logic [DELAY_BITS-1:0] elapsed_q, elapsed_nxt, elapsed_inc;
	logic [shs_pkg::COIL_BITS-1:0] coil_q;
	logic present, level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			remaining_q <= '0;
			backward_q <= 1'b0;
			elapsed_q <= '1;
			coil_q <= shs_pkg::coil_of('0);
		end else if (adv) begin
			phase_q <= phase_nxt;
			remaining_q <= remaining_nxt;
			backward_q <= backward_nxt;
			elapsed_q <= elapsed_nxt;
			coil_q <= coil_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		remaining_nxt = remaining_q;
		backward_nxt = backward_q;
		elapsed_nxt = elapsed_q;
		coil_nxt = coil_q;
		status_nxt = shs_pkg::ST_IDLE;
		// counter saturates at all ones
		elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DELAY_BITS'(1);
		present = (ctl.cmd == shs_pkg::CMD_BWD) ? sw.bwd_present : sw.fwd_present;
		level = (ctl.cmd == shs_pkg::CMD_BWD) ? ctl.bwd_level : ctl.fwd_level;
		case (ctl.cmd)
			shs_pkg::CMD_TICK: begin
				elapsed_nxt = elapsed_inc;
				if (remaining_q != '0 && elapsed_inc >= step_delay) begin
					phase_nxt = backward_q ? phase_q - shs_pkg::PHASE_BITS'(1)
						: phase_q + shs_pkg::PHASE_BITS'(1);
					coil_nxt = shs_pkg::coil_of(phase_nxt);
					elapsed_nxt = '0;
					remaining_nxt = remaining_q - COUNT_BITS'(1);
					status_nxt = shs_pkg::ST_STEP;
				end
			end
			shs_pkg::CMD_FWD, shs_pkg::CMD_BWD: begin
				if (remaining_q != '0) begin
					status_nxt = shs_pkg::ST_BUSY;
				end else if (present && !level) begin
					status_nxt = shs_pkg::ST_LIMIT;
				end else begin
					remaining_nxt = count;
					backward_nxt = (ctl.cmd == shs_pkg::CMD_BWD);
					status_nxt = shs_pkg::ST_ACCEPT;
				end
			end
			default: ; // unused code: no change, tick counter holds
		endcase
	end

endmodule

`default_nettype wire
